>>> sv/source_text_tokenizer_defines.svh
// assertion macros for the source text tokenizer
// used by source_text_tokenizer.sv, expects i_clk and i_rst_n in scope
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define STT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define STT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/stt_pkg.sv
// shared types, constants and character helpers of the source text tokenizer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package stt_pkg;

    // defaults of the top level parameters
    localparam int POS_BITS_DEF   = 16;
    localparam int MAX_LEN_DEF    = 255;
    localparam int VALUE_BITS_DEF = 31;

    // fixed widths of the token fields
    localparam int KIND_W    = 5;
    localparam int VAL_OUT_W = 31;
    localparam int POS_OUT_W = 16;
    localparam int LEN_OUT_W = 8;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef logic [KIND_W-1:0] t_kind;

    // token kinds
    localparam t_kind KIND_ID     = 5'd0;
    localparam t_kind KIND_TYPE   = 5'd1;
    localparam t_kind KIND_FNC    = 5'd2;
    localparam t_kind KIND_INT    = 5'd3;
    localparam t_kind KIND_STRING = 5'd4;
    localparam t_kind KIND_EQ     = 5'd5;
    localparam t_kind KIND_SEMI   = 5'd6;
    localparam t_kind KIND_LPAREN = 5'd7;
    localparam t_kind KIND_RPAREN = 5'd8;
    localparam t_kind KIND_LBRACE = 5'd9;
    localparam t_kind KIND_RBRACE = 5'd10;
    localparam t_kind KIND_LBRACK = 5'd11;
    localparam t_kind KIND_RBRACK = 5'd12;
    localparam t_kind KIND_COMMA  = 5'd13;
    localparam t_kind KIND_PLUS   = 5'd14;
    localparam t_kind KIND_MINUS  = 5'd15;
    localparam t_kind KIND_STAR   = 5'd16;
    localparam t_kind KIND_SLASH  = 5'd17;
    localparam t_kind KIND_BANG   = 5'd18;
    localparam t_kind KIND_AMP    = 5'd19;
    localparam t_kind KIND_AT     = 5'd20;
    localparam t_kind KIND_EOF    = 5'd21;
    localparam t_kind KIND_ERROR  = 5'd22;

    // character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // the one keyword, "fnc"
    localparam logic [7:0] KW_CHAR_0 = 8'h66;
    localparam logic [7:0] KW_CHAR_1 = 8'h6E;
    localparam logic [7:0] KW_CHAR_2 = 8'h63;
    localparam int         KW_LEN    = 3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING
    } t_lex_mode;

    // input request
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_req;

    // output token
    typedef struct packed {
        t_kind                token_kind;
        logic [VAL_OUT_W-1:0] int_value;
        logic [POS_OUT_W-1:0] start_pos;
        logic [LEN_OUT_W-1:0] token_len;
        logic                 last_of_run;
    } t_out_tok;

    // tokens produced by one request, tok0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        t_out_tok   tok0;
        t_out_tok   tok1;
    } t_lex_res;

    // result queue status
    typedef struct packed {
        logic                  valid;
        logic                  room;
        logic [FIFO_CNT_W-1:0] count;
    } t_fifo_stat;

    function automatic logic is_upper(input logic [7:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z]};
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_DIGIT_0:CH_DIGIT_9]};
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_NL, CH_TAB};
    endfunction

    // keyword letter at a given offset
    function automatic logic [7:0] kw_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = KW_CHAR_0;
            2'd1:    ch = KW_CHAR_1;
            2'd2:    ch = KW_CHAR_2;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // single character tokens; anything unknown is an error token
    function automatic t_kind punct_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_EQ:     k = KIND_EQ;
            CH_SEMI:   k = KIND_SEMI;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_COMMA:  k = KIND_COMMA;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_STAR;
            CH_SLASH:  k = KIND_SLASH;
            CH_BANG:   k = KIND_BANG;
            CH_AMP:    k = KIND_AMP;
            CH_AT:     k = KIND_AT;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

    function automatic t_out_tok mk_tok(
        input t_kind                kind,
        input logic [VAL_OUT_W-1:0] val,
        input logic [POS_OUT_W-1:0] pos,
        input logic [LEN_OUT_W-1:0] len
    );
        t_out_tok t;
        t.token_kind  = kind;
        t.int_value   = val;
        t.start_pos   = pos;
        t.token_len   = len;
        t.last_of_run = 1'b0;
        return t;
    endfunction

endpackage

>>> sv/stt_lex_core.sv
// lexer state registers and the per-byte scan step
// depends on stt_pkg; produces up to two tokens for each request it takes
`timescale 1ns / 1ps

module stt_lex_core import stt_pkg::*; #(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_in_req  i_req,
    output t_lex_res o_res
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int WIDE_W = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

    t_lex_mode             r_mode, n_mode;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_start, n_start;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [VALUE_BITS-1:0] r_num, n_num;
    logic                  r_upper, n_upper;
    logic                  r_km, n_km;

    logic [7:0]            c;
    logic [LEN_W-1:0]      len_grow;
    logic [WIDE_W-1:0]     num_ext;
    logic [WIDE_W-1:0]     num_wide;
    logic [VALUE_BITS-1:0] num_acc;

    t_out_tok              flush_tok;
    t_out_tok              idle_tok;
    t_out_tok              eof_tok;
    logic                  idle_emit;
    logic                  idle_start;
    t_lex_mode             idle_mode;
    logic [POS_BITS-1:0]   idle_pos;
    logic [LEN_W-1:0]      idle_len;
    t_kind                 ident_kind;

    logic                  flush_now;
    logic                  take_idle;
    t_lex_res              res;

    assign c = i_req.char_code;

    // saturating length step
    assign len_grow = (r_len < LEN_W'(MAX_LEN)) ? r_len + LEN_W'(1) : r_len;

    // decimal accumulate: value*10 + digit, saturating at all ones
    assign num_ext  = WIDE_W'(r_num);
    assign num_wide = (num_ext << 3) + (num_ext << 1) + WIDE_W'(c[3:0]);
    assign num_acc  = (num_wide > WIDE_W'(VAL_MAX)) ? VAL_MAX : num_wide[VALUE_BITS-1:0];

    // token of the pending run
    always_comb begin
        if (r_upper) begin
            ident_kind = KIND_TYPE;
        end else if (r_km && r_len == LEN_W'(KW_LEN)) begin
            ident_kind = KIND_FNC;
        end else begin
            ident_kind = KIND_ID;
        end
        case (r_mode)
            MODE_IDENT: begin
                flush_tok = mk_tok(ident_kind, '0, POS_OUT_W'(r_start), LEN_OUT_W'(r_len));
            end
            MODE_NUMBER: begin
                flush_tok = mk_tok(KIND_INT, VAL_OUT_W'(r_num), POS_OUT_W'(r_start),
                                   LEN_OUT_W'(r_len));
            end
            default: begin
                flush_tok = mk_tok(KIND_STRING, '0, POS_OUT_W'(r_start), LEN_OUT_W'(r_len));
            end
        endcase
        eof_tok = mk_tok(KIND_EOF, '0, POS_OUT_W'(r_pos), '0);
    end

    // byte seen from idle: skip, start a run, or a one-character token
    always_comb begin
        idle_emit  = 1'b0;
        idle_start = 1'b1;
        idle_mode  = MODE_IDLE;
        idle_pos   = r_pos;
        idle_len   = LEN_W'(1);
        idle_tok   = mk_tok(punct_kind(c), '0, POS_OUT_W'(r_pos), LEN_OUT_W'(1));
        if (is_blank(c)) begin
            idle_start = 1'b0;
        end else if (is_letter(c)) begin
            idle_mode = MODE_IDENT;
        end else if (is_digit(c)) begin
            idle_mode = MODE_NUMBER;
        end else if (c == CH_QUOTE) begin
            idle_mode = MODE_STRING;
            idle_pos  = r_pos + POS_BITS'(1);
            idle_len  = '0;
        end else begin
            idle_start = 1'b0;
            idle_emit  = 1'b1;
        end
    end

    // scan step
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_start   = r_start;
        n_len     = r_len;
        n_num     = r_num;
        n_upper   = r_upper;
        n_km      = r_km;
        flush_now = 1'b0;
        take_idle = 1'b0;
        res       = '0;

        if (i_en) begin
            if (i_req.end_of_text) begin
                // flush any open run, then end-of-file, position back to zero
                n_mode = MODE_IDLE;
                n_pos  = '0;
                if (r_mode != MODE_IDLE) begin
                    res.cnt  = 2'd2;
                    res.tok0 = flush_tok;
                    res.tok1 = eof_tok;
                end else begin
                    res.cnt  = 2'd1;
                    res.tok0 = eof_tok;
                end
            end else begin
                n_pos = r_pos + POS_BITS'(1);
                case (r_mode)
                    MODE_IDENT: begin
                        if (is_letter(c)) begin
                            n_km  = r_km && (r_len < LEN_W'(KW_LEN)) && (c == kw_char(r_len[1:0]));
                            n_len = len_grow;
                        end else begin
                            flush_now = 1'b1;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_NUMBER: begin
                        if (is_digit(c)) begin
                            n_num = num_acc;
                            n_len = len_grow;
                        end else begin
                            flush_now = 1'b1;
                            take_idle = 1'b1;
                        end
                    end
                    MODE_STRING: begin
                        if (c == CH_QUOTE) begin
                            res.cnt  = 2'd1;
                            res.tok0 = flush_tok;
                            n_mode   = MODE_IDLE;
                        end else begin
                            n_len = len_grow;
                        end
                    end
                    default: begin
                        take_idle = 1'b1;
                    end
                endcase

                // run ended by this byte, then the byte itself from idle
                if (take_idle) begin
                    n_mode = idle_mode;
                    if (idle_start) begin
                        n_start = idle_pos;
                        n_len   = idle_len;
                        n_upper = is_upper(c);
                        n_km    = (c == KW_CHAR_0);
                        n_num   = VALUE_BITS'(c[3:0]);
                    end
                    if (flush_now) begin
                        res.tok0 = flush_tok;
                        if (idle_emit) begin
                            res.cnt  = 2'd2;
                            res.tok1 = idle_tok;
                        end else begin
                            res.cnt = 2'd1;
                        end
                    end else if (idle_emit) begin
                        res.cnt  = 2'd1;
                        res.tok0 = idle_tok;
                    end
                end
            end
        end

        // mark the final token of this byte
        if (res.cnt == 2'd2) begin
            res.tok1.last_of_run = 1'b1;
        end else if (res.cnt == 2'd1) begin
            res.tok0.last_of_run = 1'b1;
        end
    end

    assign o_res = res;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_len   <= '0;
            r_num   <= '0;
            r_upper <= 1'b0;
            r_km    <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_len   <= n_len;
            r_num   <= n_num;
            r_upper <= n_upper;
            r_km    <= n_km;
        end
    end

endmodule

>>> sv/stt_out_fifo.sv
// small result queue that takes up to two tokens a cycle and gives one
// depends on stt_pkg
`timescale 1ns / 1ps

module stt_out_fifo import stt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lex_res   i_push,
    input  logic       i_pop,
    output t_out_tok   o_head,
    output t_fifo_stat o_stat
);

    t_out_tok              r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic [FIFO_PTR_W-1:0] wp_plus1;

    assign wp_plus1 = r_wp + FIFO_PTR_W'(1);

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.tok0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wp_plus1] <= i_push.tok1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + FIFO_PTR_W'(i_push.cnt);
            r_rp  <= r_rp + FIFO_PTR_W'(i_pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push.cnt) - FIFO_CNT_W'(i_pop);
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.room  = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_stat.count = r_cnt;

endmodule

>>> sv/source_text_tokenizer.sv
// Source text tokenizer, top level; uses stt_pkg, stt_lex_core, stt_out_fifo and the
// assertion macros of source_text_tokenizer_defines.svh. Takes one byte of text per
// request and returns tokens: identifiers, type names, the keyword fnc, saturating
// decimal integers, strings without their quotes, sixteen single-character kinds,
// error tokens for unknown bytes, and end-of-file on an end-of-text request, which also
// resets the byte position. A byte enters every cycle while input is not stalled; its
// tokens pass the input register, the scan step and the result queue. A request can
// yield two tokens: a byte that ends a run and is itself a token, or an end of text
// behind an open run. The output port delivers one token a cycle while i_out_stall is
// low, so such requests fill the queue faster than it drains. The four-entry result
// queue stalls input while a request is held and fewer than two entries are free.
`timescale 1ns / 1ps
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer import stt_pkg::*; #(
    parameter int POS_BITS   = POS_BITS_DEF,
    parameter int MAX_LEN    = MAX_LEN_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_tok o_out_tok
);

    logic       r_in_valid;
    t_in_req    r_in_req;
    logic       proc;
    logic       pop;
    t_lex_res   lex_res;
    t_fifo_stat fifo_stat;

    // input request register, held while the queue has no room for two tokens
    assign proc       = r_in_valid && fifo_stat.room;
    assign o_in_stall = r_in_valid && !fifo_stat.room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_req <= i_in_req;
        end
    end

    // scan step and lexer state
    stt_lex_core #(
        .POS_BITS   (POS_BITS),
        .MAX_LEN    (MAX_LEN),
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_req   (r_in_req),
        .o_res   (lex_res)
    );

    // result queue
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = fifo_stat.valid;

    stt_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (lex_res),
        .i_pop   (pop),
        .o_head  (o_out_tok),
        .o_stat  (fifo_stat)
    );

    // checks
    `STT_ASSERT_ALWAYS(a_fifo_bound, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "queue overfilled")
    `STT_ASSERT_IMPLY(a_pair_queued, o_out_valid && !o_out_tok.last_of_run, fifo_stat.count >= FIFO_CNT_W'(2), "first token of a pair without its partner")
    `STT_ASSERT_NEXT(a_eof_queued, proc && r_in_req.end_of_text, o_out_valid, "end of text gave no token")

endmodule
